@@ design/skct_pkg.sv @@
// Package for the sorted key/child table: default sizes, beat types, operation and status codes, and cell control.
`timescale 1ns / 1ps
package skct_pkg;

  // Default sizes handed to the top level parameters
  localparam int ENTRIES_DEF     = 16;
  localparam int HANDLE_BITS_DEF = 32;

  // Operation codes
  localparam logic [1:0] FUNC_FIND   = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ZERO_HANDLE = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_EXISTS      = 3'd3;
  localparam logic [2:0] ST_EMPTY       = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd5;

  // Input beat
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  key;
    logic [31:0] child_in;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] child_out;
  } out_beat_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic       cmp_en;
    logic       add_en;
    logic       rem_en;
    logic [7:0] key;
  } cell_ctl_t;

endpackage

@@ design/skct_cell.sv @@
// One slot of the table: a key, its handle, an occupied bit and compare flags.
`timescale 1ns / 1ps
module skct_cell #(
  parameter int HANDLE_BITS = skct_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  skct_pkg::cell_ctl_t    ctl,
  input  logic [HANDLE_BITS-1:0] hdl_new,
  input  logic [7:0]             left_key,
  input  logic [HANDLE_BITS-1:0] left_hdl,
  input  logic                   left_occ,
  input  logic                   left_gt,
  input  logic [7:0]             right_key,
  input  logic [HANDLE_BITS-1:0] right_hdl,
  input  logic                   right_occ,
  output logic [7:0]             key_o,
  output logic [HANDLE_BITS-1:0] hdl_o,
  output logic                   occ_o,
  output logic                   gt_o,
  output logic                   match_o
);
  import skct_pkg::*;

  logic [7:0]             key_r, key_nxt;
  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic                   occ_r, occ_nxt;
  logic                   gt_r, gt_nxt;
  logic                   match_r, match_nxt;

  // Compare flags: latched when a beat is taken, used when it is applied
  always_comb begin
    gt_nxt    = gt_r;
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      gt_nxt    = occ_r && (key_r > ctl.key);
      match_nxt = occ_r && (key_r == ctl.key);
    end
  end

  // Slot update: shift up from the left on add, down from the right on remove
  always_comb begin
    key_nxt = key_r;
    hdl_nxt = hdl_r;
    occ_nxt = occ_r;
    if (ctl.add_en) begin
      if (left_gt) begin
        key_nxt = left_key;
        hdl_nxt = left_hdl;
        occ_nxt = 1'b1;
      end else if (left_occ && (gt_r || !occ_r)) begin
        // first slot past the smaller keys: the new entry lands here
        key_nxt = ctl.key;
        hdl_nxt = hdl_new;
        occ_nxt = 1'b1;
      end
    end else if (ctl.rem_en && (gt_r || match_r)) begin
      key_nxt = right_key;
      hdl_nxt = right_hdl;
      occ_nxt = right_occ;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      gt_r    <= 1'b0;
      match_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      gt_r    <= gt_nxt;
      match_r <= match_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    hdl_r <= hdl_nxt;
  end

  assign key_o   = key_r;
  assign hdl_o   = hdl_r;
  assign occ_o   = occ_r;
  assign gt_o    = gt_r;
  assign match_o = match_r;

endmodule

@@ design/sorted_key_child_table16.sv @@
// Top level: sorted table of byte keys and child handles built as a row of slot cells.
//
//   port group   dir  beat type   handshake
//   in_*         in   in_beat_t   in_valid / in_stall
//   out_*        out  out_beat_t  out_valid / out_stall
//
// The cells compare the key of a beat in the cycle it is taken; then the
// table applies the shift and writes the result register. One beat is in
// flight at a time: a new beat stalls until the one under work is applied.
// The result register frees as soon as its beat is taken, so a held result
// only delays the apply cycle of the beat behind it. Reset (rst_n low,
// synchronous) empties the table through the occupied bits.
`timescale 1ns / 1ps
module sorted_key_child_table16 #(
  parameter int ENTRIES     = skct_pkg::ENTRIES_DEF,
  parameter int HANDLE_BITS = skct_pkg::HANDLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skct_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skct_pkg::out_beat_t out_data
);
  import skct_pkg::*;

  logic                   op_valid_r, op_valid_nxt;
  logic [1:0]             op_func_r;
  logic [7:0]             op_key_r;
  logic [HANDLE_BITS-1:0] op_hdl_r;
  logic                   out_valid_r, out_valid_nxt;
  out_beat_t              out_r, out_nxt;

  logic                   accept;
  logic                   fire;
  cell_ctl_t              ctl;
  logic [HANDLE_BITS-1:0] found_hdl;
  logic                   any_match;
  logic                   tbl_full;
  logic                   tbl_empty;
  logic                   add_ok;
  logic                   rem_ok;

  logic [7:0]             key_a [ENTRIES];
  logic [HANDLE_BITS-1:0] hdl_a [ENTRIES];
  logic [ENTRIES-1:0]     occ_v;
  logic [ENTRIES-1:0]     gt_v;
  logic [ENTRIES-1:0]     match_v;

  // Handshake: one beat at a time, apply when the result register is free
  assign accept   = in_valid && !in_stall;
  assign in_stall = op_valid_r;
  assign fire     = op_valid_r && !(out_valid_r && out_stall);

  // Hold the beat under work
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r <= in_data.func;
      op_key_r  <= in_data.key;
      op_hdl_r  <= HANDLE_BITS'(in_data.child_in);
    end
  end

  // Table-wide flags from the cells
  assign any_match = |match_v;
  assign tbl_full  = occ_v[ENTRIES-1];
  assign tbl_empty = !occ_v[0];

  always_comb begin
    found_hdl = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_v[i]) found_hdl = found_hdl | hdl_a[i];
    end
  end

  // Decode the operation and build the result
  always_comb begin
    add_ok  = 1'b0;
    rem_ok  = 1'b0;
    out_nxt = '0;
    unique case (op_func_r)
      FUNC_FIND: begin
        out_nxt.status    = ST_OK;
        out_nxt.hit       = any_match;
        out_nxt.child_out = 32'(found_hdl);
      end
      FUNC_ADD: begin
        if (op_hdl_r == '0) begin
          out_nxt.status = ST_ZERO_HANDLE;
        end else if (tbl_full) begin
          out_nxt.status = ST_FULL;
        end else if (any_match) begin
          out_nxt.status = ST_EXISTS;
        end else begin
          out_nxt.status = ST_OK;
          add_ok         = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (tbl_empty) begin
          out_nxt.status = ST_EMPTY;
        end else if (!any_match) begin
          out_nxt.status = ST_NOT_FOUND;
        end else begin
          out_nxt.status = ST_OK;
          rem_ok         = 1'b1;
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    ctl.cmp_en = accept;
    ctl.add_en = fire && add_ok;
    ctl.rem_en = fire && rem_ok;
    ctl.key    = accept ? in_data.key : op_key_r;
  end

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [7:0]             l_key;
    logic [HANDLE_BITS-1:0] l_hdl;
    logic                   l_occ;
    logic                   l_gt;
    logic [7:0]             r_key;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic                   r_occ;

    if (i == 0) begin : g_first
      assign l_key = '0;
      assign l_hdl = '0;
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
    end else begin : g_mid_l
      assign l_key = key_a[i-1];
      assign l_hdl = hdl_a[i-1];
      assign l_occ = occ_v[i-1];
      assign l_gt  = gt_v[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign r_key = '0;
      assign r_hdl = '0;
      assign r_occ = 1'b0;
    end else begin : g_mid_r
      assign r_key = key_a[i+1];
      assign r_hdl = hdl_a[i+1];
      assign r_occ = occ_v[i+1];
    end

    skct_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .hdl_new   (op_hdl_r),
      .left_key  (l_key),
      .left_hdl  (l_hdl),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .right_key (r_key),
      .right_hdl (r_hdl),
      .right_occ (r_occ),
      .key_o     (key_a[i]),
      .hdl_o     (hdl_a[i]),
      .occ_o     (occ_v[i]),
      .gt_o      (gt_v[i]),
      .match_o   (match_v[i])
    );
  end

  // Advance the control state
  always_comb begin
    op_valid_nxt = op_valid_r;
    if (accept)    op_valid_nxt = 1'b1;
    else if (fire) op_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    if (fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      op_valid_r  <= op_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Occupied slots always form a run starting at slot zero
  a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_v & (occ_v + 1'b1)) == '0)
    else $error("occupied slots are not contiguous from slot zero");

  // A key sits in at most one slot
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v))
    else $error("key matched in more than one slot");

  // A successful add grows the table by exactly one entry
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.add_en |=> $countones(occ_v) == $past($countones(occ_v)) + 1)
    else $error("add did not grow the table by one");

  // A successful remove shrinks the table by exactly one entry
  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem_en |=> $countones(occ_v) + 1 == $past($countones(occ_v)))
    else $error("remove did not shrink the table by one");

endmodule
